// ===== hw/rtl/hrsp_pkg.sv =====
// Package for the hex record stream parser.
// Result type, field positions, record types and result kinds.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hrsp_pkg;

    // Offsets from the first start pattern byte
    localparam logic [8:0] POS_IDLE  = 9'd0;
    localparam logic [8:0] POS_COUNT = 9'd4;
    localparam logic [8:0] POS_ADDRH = 9'd5;
    localparam logic [8:0] POS_ADDRL = 9'd6;
    localparam logic [8:0] POS_TYPE  = 9'd7;
    localparam logic [8:0] POS_DATA  = 9'd8;

    // Record types
    localparam logic [7:0] TYPE_DATA    = 8'h00;
    localparam logic [7:0] TYPE_EOF     = 8'h01;
    localparam logic [7:0] TYPE_EXT_LIN = 8'h04;

    // Result kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  record_index;
        logic [7:0]  byte_offset;
        logic [15:0] low_address;
        logic [7:0]  data_value;
        logic [7:0]  record_type;
        logic        checksum_ok;
        logic [15:0] high_address;
        logic        end_of_file;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hrsp_ifs.sv =====
// Stream interfaces of the hex record stream parser.
// Valid/ready channels; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface hrsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface hrsp_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  record_index;
    logic [7:0]  byte_offset;
    logic [15:0] low_address;
    logic [7:0]  data_value;
    logic [7:0]  record_type;
    logic        checksum_ok;
    logic [15:0] high_address;
    logic        end_of_file;

    modport source (output valid, output kind, output record_index, output byte_offset,
                    output low_address, output data_value, output record_type,
                    output checksum_ok, output high_address, output end_of_file,
                    input ready);
    modport sink   (input valid, input kind, input record_index, input byte_offset,
                    input low_address, input data_value, input record_type,
                    input checksum_ok, input high_address, input end_of_file,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hrsp_parse.sv =====
// Record parser state and per-byte update logic.
// Depends on hrsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hrsp_parse
    import hrsp_pkg::*;
#(
    parameter int MAX_RECORDS = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [7:0]  byte_value,
    input  wire logic        last_byte,
    input  wire logic [31:0] start_marker,
    output result_t          result,
    output logic             result_valid
);

    localparam logic [7:0] CNT_TOP = 8'(MAX_RECORDS - 1);

    logic [23:0] window_reg,  window_next;
    logic [8:0]  pos_reg,     pos_next;
    logic [7:0]  count_reg,   count_next;
    logic [15:0] addr_reg,    addr_next;
    logic [7:0]  type_reg,    type_next;
    logic [7:0]  sum_reg,     sum_next;
    logic [7:0]  rec_cnt_reg, rec_cnt_next;
    logic [15:0] upper_reg,   upper_next;

    logic [31:0] four;
    logic [8:0]  csum_pos;
    logic [7:0]  offset;
    logic [7:0]  cur_index;

    assign four      = {window_reg, byte_value};
    assign csum_pos  = {1'b0, count_reg} + POS_DATA;
    assign offset    = 8'(pos_reg - POS_DATA);
    assign cur_index = (rec_cnt_reg == 8'd0) ? CNT_TOP : rec_cnt_reg - 8'd1;

    always_comb
    begin
        window_next  = four[23:0];
        pos_next     = pos_reg;
        count_next   = count_reg;
        addr_next    = addr_reg;
        type_next    = type_reg;
        sum_next     = sum_reg;
        rec_cnt_next = rec_cnt_reg;
        upper_next   = upper_reg;

        result_valid        = 1'b0;
        result.kind         = KIND_DATA;
        result.record_index = cur_index;
        result.byte_offset  = 8'd0;
        result.low_address  = addr_reg;
        result.data_value   = 8'd0;
        result.record_type  = type_reg;
        result.checksum_ok  = 1'b0;
        result.high_address = upper_reg;
        result.end_of_file  = 1'b0;

        if (four == start_marker)
        begin
            pos_next     = POS_COUNT;
            count_next   = 8'd0;
            addr_next    = 16'd0;
            type_next    = 8'd0;
            sum_next     = 8'd0;
            rec_cnt_next = (rec_cnt_reg == CNT_TOP) ? 8'd0 : rec_cnt_reg + 8'd1;
        end
        else if (pos_reg != POS_IDLE)
        begin
            if (pos_reg >= POS_DATA && pos_reg == csum_pos)
            begin
                // checksum byte closes the record
                result_valid       = 1'b1;
                result.kind        = KIND_DONE;
                result.checksum_ok = ((8'd0 - sum_reg) == byte_value);
                result.end_of_file = (type_reg == TYPE_EOF);
                pos_next           = POS_IDLE;
            end
            else
            begin
                sum_next = sum_reg + byte_value;
                if (pos_reg == POS_COUNT)
                    count_next = byte_value;
                else if (pos_reg == POS_ADDRH)
                    addr_next = {byte_value, addr_reg[7:0]};
                else if (pos_reg == POS_ADDRL)
                    addr_next = {addr_reg[15:8], byte_value};
                else if (pos_reg == POS_TYPE)
                    type_next = byte_value;
                else if (type_reg == TYPE_DATA)
                begin
                    result_valid       = 1'b1;
                    result.byte_offset = offset;
                    result.data_value  = byte_value;
                end
                else if (type_reg == TYPE_EXT_LIN)
                begin
                    if (offset == 8'd0)
                        upper_next = {byte_value, 8'd0};
                    else if (offset == 8'd1)
                        upper_next = {upper_reg[15:8], byte_value};
                end
                pos_next = pos_reg + 9'd1;
            end
        end

        if (last_byte)
        begin
            rec_cnt_next = 8'd0;
            window_next  = 24'd0;
            pos_next     = POS_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= '0;
            pos_reg     <= POS_IDLE;
            count_reg   <= '0;
            addr_reg    <= '0;
            type_reg    <= '0;
            sum_reg     <= '0;
            rec_cnt_reg <= '0;
            upper_reg   <= '0;
        end
        else if (step)
        begin
            window_reg  <= window_next;
            pos_reg     <= pos_next;
            count_reg   <= count_next;
            addr_reg    <= addr_next;
            type_reg    <= type_next;
            sum_reg     <= sum_next;
            rec_cnt_reg <= rec_cnt_next;
            upper_reg   <= upper_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/hrsp_outbuf.sv =====
// Two-entry result buffer between the parser and the output channel.
// Depends on hrsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hrsp_outbuf
    import hrsp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    input  wire logic    pop,
    output result_t      head,
    output logic         not_empty,
    output logic         full
);

    result_t    slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;

    assign head      = slot_reg[rd_ptr_reg];
    assign not_empty = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/hex_record_stream_parser_core.sv =====
// Top level of the hex record stream parser.
// Depends on hrsp_pkg, hrsp_ifs, hrsp_parse and hrsp_outbuf.
//
//  channel       dir  payload                               transfer when
//  in_stream     in   byte_value[7:0], last_byte            valid & ready
//  out_stream    out  kind .. end_of_file (result_t)        valid & ready
//  start_marker  in   32-bit pattern, start_marker_we       we high at clk edge
//
// Cycles: one byte per cycle while the output buffer has room. A byte is taken
// into an input register, parsed from there, and its result (if any) is written
// into a two-entry output buffer that drives the output channel.
// Reset: rst_n asynchronous, active low; clears parser state, marker and buffers.
// Stalls: the parse step waits only while the output buffer holds two results;
// the input register keeps taking a byte whenever the parse step moves.
`timescale 1ns / 1ps
`default_nettype none

module hex_record_stream_parser_core
    import hrsp_pkg::*;
#(
    parameter int MAX_RECORDS = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    hrsp_in_if.sink          in_stream,
    hrsp_out_if.source       out_stream,
    input  wire logic        start_marker_we,
    input  wire logic [31:0] start_marker
);

    // configuration register: pattern, first byte in bits 31..24
    logic [31:0] marker_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            marker_reg <= 32'd0;
        else if (start_marker_we)
            marker_reg <= start_marker;
    end

    // input register stage
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    logic       step;
    logic       buf_full;

    // parse only with room for a result, so nothing is ever dropped
    assign step            = s1_valid_reg && !buf_full;
    assign in_stream.ready = !s1_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_stream.ready)
            s1_valid_reg <= in_stream.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_stream.valid && in_stream.ready)
        begin
            s1_byte_reg <= in_stream.byte_value;
            s1_last_reg <= in_stream.last_byte;
        end
    end

    // parser: window compare, field capture, checksum add
    result_t parse_result;
    logic    parse_valid;

    hrsp_parse #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .byte_value   (s1_byte_reg),
        .last_byte    (s1_last_reg),
        .start_marker (marker_reg),
        .result       (parse_result),
        .result_valid (parse_valid)
    );

    // output buffer decouples the parser from sink stalls
    result_t head;
    logic    buf_not_empty;

    hrsp_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step && parse_valid),
        .push_data (parse_result),
        .pop       (out_stream.valid && out_stream.ready),
        .head      (head),
        .not_empty (buf_not_empty),
        .full      (buf_full)
    );

    assign out_stream.valid        = buf_not_empty;
    assign out_stream.kind         = head.kind;
    assign out_stream.record_index = head.record_index;
    assign out_stream.byte_offset  = head.byte_offset;
    assign out_stream.low_address  = head.low_address;
    assign out_stream.data_value   = head.data_value;
    assign out_stream.record_type  = head.record_type;
    assign out_stream.checksum_ok  = head.checksum_ok;
    assign out_stream.high_address = head.high_address;
    assign out_stream.end_of_file  = head.end_of_file;

endmodule

`default_nettype wire

// ===== tb/sv/tb_hex_record_stream_parser_core.sv =====
// Testbench for hex_record_stream_parser_core: byte stream in, data and
// record-complete results out, checked against an in-bench parser model.
// Depends on hrsp_pkg, hrsp_in_if / hrsp_out_if and the RTL under test.
`timescale 1ns / 1ps

module tb_hex_record_stream_parser_core;
    import hrsp_pkg::*;

    // One stimulus row: the byte, its end-of-buffer flag and, for a few
    // rows, a hand-written result that replaces the model's prediction.
    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       typed;
        result_t    want;
    } stim_t;

    localparam result_t NO_RESULT  = '0;
    localparam int      DRAIN_MAX  = 20000;  // cycles allowed for results to drain
    localparam int      SETTLE_CYC = 4;      // lets the input register and parser settle
    localparam int      PHASE_ITEMS = 20;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start_marker_we;
    logic [31:0] start_marker;

    hrsp_in_if  in_if ();
    hrsp_out_if out_if ();

    hex_record_stream_parser_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_stream       (in_if),
        .out_stream      (out_if),
        .start_marker_we (start_marker_we),
        .start_marker    (start_marker)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Parser model state, at the block's own widths
    // ------------------------------------------------------------------
    logic [31:0] pattern_q;
    logic [23:0] window_q;
    logic [8:0]  pos_q;
    logic [7:0]  count_q;
    logic [15:0] addr_q;
    logic [7:0]  type_q;
    logic [7:0]  sum_q;
    logic [7:0]  records_q;
    logic [15:0] upper_q;

    result_t pending_results[$];
    stim_t   stim_q[$];
    int      mismatch_count = 0;

    // Idle control: percentages per side, and a calm flag that opens
    // stretches where neither side idles.
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit calm = 1'b0;

    // Carried alongside the payload so the monitor sees which row was taken.
    logic    item_typed;
    result_t item_want;

    task automatic reset_parser();
        pattern_q = '0;
        window_q  = '0;
        pos_q     = POS_IDLE;
        count_q   = '0;
        addr_q    = '0;
        type_q    = '0;
        sum_q     = '0;
        records_q = '0;
        upper_q   = '0;
    endtask

    // One byte through the parser; returns the result it causes, if any.
    task automatic advance_parser(input logic [7:0] b, input logic last,
                                  output bit produced, output result_t r);
        logic [31:0] four;
        logic [8:0]  k;
        four     = {window_q, b};
        window_q = four[23:0];
        produced = 1'b0;
        r        = NO_RESULT;
        if (four == pattern_q) begin
            // pattern completes: open a new record, drop any open one
            pos_q     = POS_COUNT;
            count_q   = '0;
            addr_q    = '0;
            type_q    = '0;
            sum_q     = '0;
            records_q = records_q + 8'd1;
        end
        else if (pos_q != POS_IDLE) begin
            if (pos_q >= POS_DATA && pos_q == {1'b0, count_q} + POS_DATA) begin
                // checksum byte closes the record
                r.kind         = KIND_DONE;
                r.record_index = records_q - 8'd1;
                r.low_address  = addr_q;
                r.record_type  = type_q;
                r.checksum_ok  = (b == (~sum_q + 8'd1));
                r.high_address = upper_q;
                r.end_of_file  = (type_q == TYPE_EOF);
                produced       = 1'b1;
                pos_q          = POS_IDLE;
            end
            else begin
                sum_q = sum_q + b;
                case (pos_q)
                    POS_COUNT: count_q = b;
                    POS_ADDRH: addr_q[15:8] = b;
                    POS_ADDRL: addr_q[7:0] = b;
                    POS_TYPE:  type_q = b;
                    default:
                    begin
                        k = pos_q - POS_DATA;
                        if (type_q == TYPE_DATA) begin
                            r.kind         = KIND_DATA;
                            r.record_index = records_q - 8'd1;
                            r.byte_offset  = k[7:0];
                            r.low_address  = addr_q;
                            r.data_value   = b;
                            r.record_type  = type_q;
                            r.high_address = upper_q;
                            produced       = 1'b1;
                        end
                        else if (type_q == TYPE_EXT_LIN) begin
                            // short records load only what they carry
                            if (k == 9'd0)
                                upper_q = {b, 8'h00};
                            else if (k == 9'd1)
                                upper_q[7:0] = b;
                        end
                    end
                endcase
                pos_q = pos_q + 9'd1;
            end
        end
        if (last) begin
            records_q = '0;
            window_q  = '0;
            pos_q     = POS_IDLE;
        end
    endtask

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t ns: MISMATCH %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
            flag_mismatch($sformatf("%s expected %0h actual %0h", name, want, got));
    endtask

    // ------------------------------------------------------------------
    // Monitor: checks each output transfer, runs the model on each input
    // transfer. Values are read as they stood before the edge.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        result_t got;
        result_t want;
        result_t predicted;
        bit      produced;
        if (rst_n) begin
            if (out_if.valid && out_if.ready) begin
                got = '{out_if.kind, out_if.record_index, out_if.byte_offset,
                        out_if.low_address, out_if.data_value, out_if.record_type,
                        out_if.checksum_ok, out_if.high_address, out_if.end_of_file};
                if (pending_results.size() == 0)
                    flag_mismatch($sformatf("result with nothing expected: %p", got));
                else begin
                    want = pending_results.pop_front();
                    compare_field("kind", 32'(want.kind), 32'(got.kind));
                    compare_field("record_index", 32'(want.record_index),
                                  32'(got.record_index));
                    compare_field("byte_offset", 32'(want.byte_offset),
                                  32'(got.byte_offset));
                    compare_field("low_address", 32'(want.low_address),
                                  32'(got.low_address));
                    compare_field("data_value", 32'(want.data_value),
                                  32'(got.data_value));
                    compare_field("record_type", 32'(want.record_type),
                                  32'(got.record_type));
                    compare_field("checksum_ok", 32'(want.checksum_ok),
                                  32'(got.checksum_ok));
                    compare_field("high_address", 32'(want.high_address),
                                  32'(got.high_address));
                    compare_field("end_of_file", 32'(want.end_of_file),
                                  32'(got.end_of_file));
                end
            end
            if (in_if.valid && in_if.ready) begin
                advance_parser(in_if.byte_value, in_if.last_byte, produced, predicted);
                if (produced)
                    pending_results.push_back(item_typed ? item_want : predicted);
            end
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
        out_if.ready <= calm || ($urandom_range(99) >= rx_idle_pct);

    // ------------------------------------------------------------------
    // Directed rows, start pattern at its reset value of zero.
    // Record 0: data record right after reset (window starts zeroed, so a
    // single zero byte completes the pattern). Record 1: short type 4
    // with a bad checksum. Record 2: end-of-file record closed by the
    // last byte of the buffer.
    // ------------------------------------------------------------------
    stim_t directed_rows [26] = '{
        '{8'h00, 1'b0, 1'b0, NO_RESULT},  // pattern, record 0 opens
        '{8'h01, 1'b0, 1'b0, NO_RESULT},  // count
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},  // address high
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},  // address low
        '{8'h00, 1'b0, 1'b0, NO_RESULT},  // type data
        '{8'hAB, 1'b0, 1'b1, result_t'{KIND_DATA, 8'd0, 8'd0, 16'hFFFF, 8'hAB,
                                       TYPE_DATA, 1'b0, 16'h0000, 1'b0}},
        '{8'h56, 1'b0, 1'b1, result_t'{KIND_DONE, 8'd0, 8'd0, 16'hFFFF, 8'h00,
                                       TYPE_DATA, 1'b1, 16'h0000, 1'b0}},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},  // four zeros, record 1 opens
        '{8'h01, 1'b0, 1'b0, NO_RESULT},
        '{8'h12, 1'b0, 1'b0, NO_RESULT},
        '{8'h34, 1'b0, 1'b0, NO_RESULT},
        '{8'h04, 1'b0, 1'b0, NO_RESULT},  // type 4, one data byte only
        '{8'h80, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b1, result_t'{KIND_DONE, 8'd1, 8'd0, 16'h1234, 8'h00,
                                       TYPE_EXT_LIN, 1'b0, 16'h8000, 1'b0}},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, 1'b0, NO_RESULT},  // record 2 opens
        '{8'h01, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, 1'b0, NO_RESULT},
        '{8'h01, 1'b0, 1'b0, NO_RESULT},  // type end of file
        '{8'h7F, 1'b0, 1'b0, NO_RESULT},
        '{8'h81, 1'b1, 1'b1, result_t'{KIND_DONE, 8'd2, 8'd0, 16'hFFFF, 8'h00,
                                       TYPE_EOF, 1'b1, 16'h8000, 1'b1}}
    };

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] value, input logic last);
        stim_t s;
        s       = '0;
        s.value = value;
        s.last  = last;
        stim_q.push_back(s);
    endtask

    function automatic logic [7:0] pick_type();
        case ($urandom_range(7))
            0, 1, 2, 3: return TYPE_DATA;
            4:          return TYPE_EOF;
            5:          return TYPE_EXT_LIN;
            default:    return 8'($urandom_range(255));
        endcase
    endfunction

    // Pattern, header, data and checksum; keep < 0 sends the whole record,
    // otherwise only the first keep bytes after the pattern.
    task automatic add_record(input logic [31:0] marker, input int count,
                              input logic [7:0] rtype, input int keep);
        logic [7:0] body[$];
        logic [7:0] total;
        bit         trim;
        int         n;
        // right after a last byte the window is zero, so leading zero
        // pattern bytes may be left out
        trim = stim_q.size() != 0 && stim_q[$].last && $urandom_range(1);
        for (int i = 3; i >= 0; i--) begin
            if (!(trim && marker[i*8 +: 8] == 8'h00)) begin
                trim = 1'b0;
                push_byte(marker[i*8 +: 8], 1'b0);
            end
        end
        body.push_back(8'(count));
        body.push_back(8'($urandom_range(255)));
        body.push_back(8'($urandom_range(255)));
        body.push_back(rtype);
        repeat (count)
            body.push_back(8'($urandom_range(255)));
        total = '0;
        foreach (body[i])
            total = total + body[i];
        body.push_back(($urandom_range(99) < 85) ? ~total + 8'd1
                                                 : 8'($urandom_range(255)));
        n = (keep < 0 || keep > body.size()) ? body.size() : keep;
        for (int i = 0; i < n; i++)
            push_byte(body[i], (i == body.size() - 1) ? ($urandom_range(6) == 0)
                                                      : ($urandom_range(150) == 0));
    endtask

    task automatic build_phase(input int ph, input logic [31:0] marker);
        int target;
        int pick;
        int count;
        stim_q.delete();
        if (ph == 1)
            add_record(marker, 255, TYPE_DATA, -1);  // longest record
        if (ph == 2) begin
            // self-overlapping pattern: from the fourth byte of the run on, every
            // byte reopens a record, so the record index wraps
            repeat ($urandom_range(255, 262))
                push_byte(marker[7:0], 1'b0);
            add_record(marker, 2, TYPE_DATA, -1);
        end
        target = stim_q.size() + PHASE_ITEMS;
        while (stim_q.size() < target) begin
            pick  = $urandom_range(99);
            count = ($urandom_range(24) == 0) ? $urandom_range(16, 64) : $urandom_range(0, 6);
            if (pick < 70)
                add_record(marker, count, pick_type(), -1);
            else if (pick < 82)
                add_record(marker, count, pick_type(), $urandom_range(1, count + 4));
            else
                repeat ($urandom_range(1, 6))
                    push_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
        end
    endtask

    // One input transfer, with random sender gaps ahead of it
    task automatic send_item(input stim_t s);
        while (!calm && $urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid      <= 1'b1;
        in_if.byte_value <= s.value;
        in_if.last_byte  <= s.last;
        item_typed       <= s.typed;
        item_want        <= s.want;
        do
            @(posedge clk);
        while (!in_if.ready);
    endtask

    // Sender holds off until every expected result is in, then lets the
    // pipeline settle so items without results are through as well.
    task automatic drain_results();
        int waited;
        in_if.valid <= 1'b0;
        waited = 0;
        do begin
            @(posedge clk);
            waited++;
        end while (pending_results.size() != 0 && waited < DRAIN_MAX);
        if (pending_results.size() != 0) begin
            flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
            pending_results.delete();
        end
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic set_marker(input logic [31:0] value);
        @(posedge clk);
        start_marker    <= value;
        start_marker_we <= 1'b1;
        pattern_q = value;
        @(posedge clk);
        start_marker_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [31:0] marker_plan [6];
        rst_n            = 1'b0;
        in_if.valid      <= 1'b0;
        in_if.byte_value <= '0;
        in_if.last_byte  <= 1'b0;
        start_marker_we  <= 1'b0;
        start_marker     <= '0;
        item_typed       <= 1'b0;
        item_want        <= NO_RESULT;
        reset_parser();

        marker_plan[0] = 32'hFFFF_FFFF;
        marker_plan[1] = 32'h0000_023A;       // leading zeros: early match
        marker_plan[2] = 32'h3A3A_3A3A;
        marker_plan[3] = $urandom;
        marker_plan[4] = $urandom;
        marker_plan[5] = 32'h0000_0000;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 35;
        rx_idle_pct = 79;
        foreach (directed_rows[i])
            send_item(directed_rows[i]);
        drain_results();

        for (int ph = 0; ph < 6; ph++) begin
            // receiver-heavy idling, then sender-heavy, then none
            tx_idle_pct = (ph < 2) ? 35 : (ph < 4) ? 79 : 0;
            rx_idle_pct = (ph < 2) ? 79 : (ph < 4) ? 35 : 0;
            set_marker(marker_plan[ph]);
            build_phase(ph, marker_plan[ph]);
            foreach (stim_q[i]) begin
                if ($urandom_range(39) == 0)
                    calm = !calm;
                send_item(stim_q[i]);
            end
            calm = 1'b0;
            drain_results();
        end

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #1_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
